// File: rtl/core/wfst_pkg.sv
// ----------------------------------------------------------------------------
// wfst_pkg
// Shared constants and types for the weighted fifo sum tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package wfst_pkg;

    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_TAG_BITS    = 32;
    localparam int DEF_WEIGHT_BITS = 16;

    // cells examined per scan cycle of a query
    localparam int SCAN_GROUP = 16;

    localparam int ACTION_W = 2;
    localparam int TAG_W    = 32;
    localparam int WEIGHT_W = 16;
    localparam int VALUE_W  = 24;
    localparam int AMOUNT_W = 24;
    localparam int TOTAL_W  = 24;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd3;

    typedef struct packed {
        logic append;
        logic pop;
    } wfst_cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/wfst_cell.sv
// ----------------------------------------------------------------------------
// wfst_cell
// One entry slot: tag plus start and stop of its cumulative weight span.
// Shifts from its upper neighbor on pop, loads on append at its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module wfst_cell
    import wfst_pkg::*;
#(
    parameter int INDEX    = 0,
    parameter int TAG_BITS = DEF_TAG_BITS,
    parameter int POS_BITS = 24,
    parameter int CNT_BITS = 9
)(
    input  wire logic                clk,
    input  wire wfst_cell_ctl_t      ctl,
    input  wire logic [CNT_BITS-1:0] count,
    input  wire logic [TAG_BITS-1:0] wr_tag,
    input  wire logic [POS_BITS-1:0] wr_start,
    input  wire logic [POS_BITS-1:0] wr_stop,
    input  wire logic [POS_BITS-1:0] pop_amount,
    input  wire logic [POS_BITS-1:0] query_pos,
    input  wire logic [TAG_BITS-1:0] nb_tag,
    input  wire logic [POS_BITS-1:0] nb_start,
    input  wire logic [POS_BITS-1:0] nb_stop,
    output logic      [TAG_BITS-1:0] tag,
    output logic      [POS_BITS-1:0] start_pos,
    output logic      [POS_BITS-1:0] stop_pos,
    output logic      [TAG_BITS-1:0] hit_tag,
    output logic      [POS_BITS-1:0] hit_start
);

    localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

    logic [TAG_BITS-1:0] tag_reg,   tag_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] stop_reg,  stop_next;
    logic                hit;

    always_comb
    begin
        tag_next   = tag_reg;
        start_next = start_reg;
        stop_next  = stop_reg;
        if (ctl.pop)
        begin
            tag_next   = nb_tag;
            start_next = nb_start - pop_amount;
            stop_next  = nb_stop - pop_amount;
        end
        else if (ctl.append && (count == MY_INDEX))
        begin
            tag_next   = wr_tag;
            start_next = wr_start;
            stop_next  = wr_stop;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg   <= tag_next;
        start_reg <= start_next;
        stop_reg  <= stop_next;
    end

    // zero-width spans never match
    assign hit = (MY_INDEX < count) && (query_pos >= start_reg) && (query_pos < stop_reg);

    assign tag       = tag_reg;
    assign start_pos = start_reg;
    assign stop_pos  = stop_reg;
    assign hit_tag   = hit ? tag_reg : '0;
    assign hit_start = hit ? start_reg : '0;

endmodule

`default_nettype wire

// File: rtl/core/weighted_fifo_sum_tree_top.sv
// ----------------------------------------------------------------------------
// weighted_fifo_sum_tree_top
// Ordered list of weighted entries with running total, append, query, pop.
//
// channel   signals                                          direction
// command   start, action, item_tag, weight,                 in
//           query_value; busy                                out
// result    done, result_tag, result_amount, total_weight,   out
//           entry_count, status
//
// append, pop and invalid actions: result on done the next cycle,
// busy stays low.
// query: one group of 16 cells per scan cycle, busy high while scanning;
// a query on an empty list or beyond the total answers like an append.
// reset empties the list at once, no clearing pass.
// results cannot be stalled; each word is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_fifo_sum_tree_top
    import wfst_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [TAG_W-1:0]    item_tag,
    input  wire logic [WEIGHT_W-1:0] weight,
    input  wire logic [VALUE_W-1:0]  query_value,
    output logic                     done,
    output logic      [TAG_W-1:0]    result_tag,
    output logic      [AMOUNT_W-1:0] result_amount,
    output logic      [TOTAL_W-1:0]  total_weight,
    output logic      [COUNT_W-1:0]  entry_count,
    output logic      [STATUS_W-1:0] status
);

    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int PB_RAW     = WEIGHT_BITS + $clog2(CAPACITY);
    localparam int POS_BITS   = (PB_RAW > VALUE_W) ? PB_RAW : VALUE_W;
    localparam int NUM_GROUPS = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GRP_BITS   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    localparam logic [CNT_BITS-1:0] CAP_COUNT = CNT_BITS'(CAPACITY);
    localparam logic [GRP_BITS-1:0] LAST_GRP  = GRP_BITS'(NUM_GROUPS - 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [POS_BITS-1:0] total_reg, total_next;
    logic [POS_BITS-1:0] qpos_reg,  qpos_next;
    logic [GRP_BITS-1:0] grp_reg,   grp_next;
    logic [TAG_BITS-1:0] acc_tag_reg,   acc_tag_next;
    logic [POS_BITS-1:0] acc_start_reg, acc_start_next;
    logic                done_reg,   done_next;
    logic [TAG_W-1:0]    rtag_reg,   rtag_next;
    logic [AMOUNT_W-1:0] ramt_reg,   ramt_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    wfst_cell_ctl_t      cell_ctl;
    logic [TAG_BITS-1:0]    tag_in;
    logic [WEIGHT_BITS-1:0] weight_in;
    logic [POS_BITS-1:0]    wr_stop;
    logic [POS_BITS-1:0]    value_in;
    logic [POS_BITS-1:0]    pop_amount;
    logic                   accept;

    logic [TAG_BITS-1:0] cell_tag   [CAPACITY];
    logic [POS_BITS-1:0] cell_start [CAPACITY];
    logic [POS_BITS-1:0] cell_stop  [CAPACITY];
    logic [TAG_BITS-1:0] cell_htag  [CAPACITY];
    logic [POS_BITS-1:0] cell_hstart[CAPACITY];

    logic [TAG_BITS-1:0] grp_tag   [NUM_GROUPS][SCAN_GROUP];
    logic [POS_BITS-1:0] grp_start [NUM_GROUPS][SCAN_GROUP];
    logic [TAG_BITS-1:0] grp_tag_or;
    logic [POS_BITS-1:0] grp_start_or;
    logic [POS_BITS-1:0] found_start;

    assign accept     = (state_reg == S_IDLE) && start;
    assign tag_in     = TAG_BITS'(item_tag);
    assign weight_in  = WEIGHT_BITS'(weight);
    assign wr_stop    = total_reg + POS_BITS'(weight_in);
    assign value_in   = POS_BITS'(query_value);
    assign pop_amount = cell_stop[0];

    assign cell_ctl.append = accept && (action == ACT_APPEND) && (count_reg < CAP_COUNT);
    assign cell_ctl.pop    = accept && (action == ACT_POP) && (count_reg != '0);

    // chain of entry cells, front at index zero
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [TAG_BITS-1:0] nb_tag;
        logic [POS_BITS-1:0] nb_start;
        logic [POS_BITS-1:0] nb_stop;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign nb_tag   = '0;
            assign nb_start = '0;
            assign nb_stop  = '0;
        end
        else
        begin : g_link
            assign nb_tag   = cell_tag[i+1];
            assign nb_start = cell_start[i+1];
            assign nb_stop  = cell_stop[i+1];
        end

        wfst_cell #(
            .INDEX    (i),
            .TAG_BITS (TAG_BITS),
            .POS_BITS (POS_BITS),
            .CNT_BITS (CNT_BITS)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .count      (count_reg),
            .wr_tag     (tag_in),
            .wr_start   (total_reg),
            .wr_stop    (wr_stop),
            .pop_amount (pop_amount),
            .query_pos  (qpos_reg),
            .nb_tag     (nb_tag),
            .nb_start   (nb_start),
            .nb_stop    (nb_stop),
            .tag        (cell_tag[i]),
            .start_pos  (cell_start[i]),
            .stop_pos   (cell_stop[i]),
            .hit_tag    (cell_htag[i]),
            .hit_start  (cell_hstart[i])
        );
    end

    for (genvar g = 0; g < NUM_GROUPS; g++)
    begin : g_grp
        for (genvar j = 0; j < SCAN_GROUP; j++)
        begin : g_slot
            if (g * SCAN_GROUP + j < CAPACITY)
            begin : g_used
                assign grp_tag[g][j]   = cell_htag[g*SCAN_GROUP+j];
                assign grp_start[g][j] = cell_hstart[g*SCAN_GROUP+j];
            end
            else
            begin : g_pad
                assign grp_tag[g][j]   = '0;
                assign grp_start[g][j] = '0;
            end
        end
    end

    // at most one cell matches, so or-ing picks it
    always_comb
    begin
        grp_tag_or   = '0;
        grp_start_or = '0;
        for (int j = 0; j < SCAN_GROUP; j++)
        begin
            grp_tag_or   = grp_tag_or | grp_tag[grp_reg][j];
            grp_start_or = grp_start_or | grp_start[grp_reg][j];
        end
    end

    assign found_start = acc_start_reg | grp_start_or;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        qpos_next      = qpos_reg;
        grp_next       = grp_reg;
        acc_tag_next   = acc_tag_reg;
        acc_start_next = acc_start_reg;
        done_next      = 1'b0;
        rtag_next      = rtag_reg;
        ramt_next      = ramt_reg;
        status_next    = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rtag_next   = '0;
                    ramt_next   = '0;
                    status_next = ST_OK;
                    case (action)
                        ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg >= CAP_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                total_next = wr_stop;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (value_in >= total_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BEYOND;
                            end
                            else
                            begin
                                state_next     = S_SCAN;
                                qpos_next      = value_in;
                                grp_next       = '0;
                                acc_tag_next   = '0;
                                acc_start_next = '0;
                            end
                        end
                        ACT_POP:
                        begin
                            done_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rtag_next  = TAG_W'(cell_tag[0]);
                                ramt_next  = AMOUNT_W'(pop_amount);
                                count_next = count_reg - 1'b1;
                                total_next = total_reg - pop_amount;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                acc_tag_next   = acc_tag_reg | grp_tag_or;
                acc_start_next = found_start;
                if (grp_reg == LAST_GRP)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    rtag_next   = TAG_W'(acc_tag_reg | grp_tag_or);
                    ramt_next   = AMOUNT_W'(qpos_reg - found_start);
                    status_next = ST_OK;
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            grp_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            grp_reg    <= grp_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qpos_reg      <= qpos_next;
        acc_tag_reg   <= acc_tag_next;
        acc_start_reg <= acc_start_next;
        rtag_reg      <= rtag_next;
        ramt_reg      <= ramt_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign result_tag    = rtag_reg;
    assign result_amount = ramt_reg;
    assign status        = status_reg;
    assign total_weight  = TOTAL_W'(total_reg);
    assign entry_count   = COUNT_W'(count_reg);

endmodule

`default_nettype wire

// File: rtl/core/wfst_checker.sv
// ----------------------------------------------------------------------------
// wfst_checker
// Port-level checks on the weighted fifo sum tree, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfst_checker
    import wfst_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [ACTION_W-1:0] action,
    input wire logic                done,
    input wire logic [TAG_W-1:0]    result_tag,
    input wire logic [AMOUNT_W-1:0] result_amount,
    input wire logic [COUNT_W-1:0]  entry_count,
    input wire logic [STATUS_W-1:0] status
);

    // append answers in the next cycle
    a_append_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_APPEND)) |=> done)
        else $error("append without result");

    // a finished scan always delivers a word
    a_scan_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query ended without result");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (entry_count == '0))
        else $error("empty status with entries held");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (entry_count == COUNT_W'(CAPACITY)))
        else $error("full status below capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((result_tag == '0) && (result_amount == '0)))
        else $error("failed action with nonzero payload");

endmodule

bind weighted_fifo_sum_tree_top wfst_checker #(
    .CAPACITY (CAPACITY)
) u_wfst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .done          (done),
    .result_tag    (result_tag),
    .result_amount (result_amount),
    .entry_count   (entry_count),
    .status        (status)
);

`default_nettype wire
